FILE: rtl/cmm_pkg.sv
`default_nettype none

package cmm_pkg;

	localparam int MAX_SIZE = 8;
	localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CNT_W    = ADDR_W + 1;
	localparam int SIZE_W   = 4;
	localparam int IDX_W    = 3;
	localparam int DATA_W   = 16;
	localparam int WORD_W   = 2 * DATA_W;
	localparam int PROD_W   = 2 * DATA_W;
	localparam int RES_W    = 36;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [SIZE_W-1:0] size_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [RES_W-1:0]  res_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] a_real;
		logic signed [DATA_W-1:0] a_imag;
		logic signed [DATA_W-1:0] b_real;
		logic signed [DATA_W-1:0] b_imag;
	} in_word_t;

	typedef struct packed {
		idx_t row_index;
		idx_t col_index;
		res_t r_real;
		res_t r_imag;
		logic last;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_WAIT,
		ST_ISSUE
	} state_t;

	typedef struct packed {
		logic  wr_en;
		addr_t wr_addr;
		logic  rd_en;
		addr_t a_addr;
		addr_t b_addr;
		logic  first;
		logic  fin;
		idx_t  row;
		idx_t  col;
		logic  last;
	} cmd_t;

	typedef struct packed {
		logic pipe_empty;
		logic out_full;
	} sts_t;

endpackage

`default_nettype wire

FILE: rtl/cmm_ctrl.sv
`default_nettype none

module cmm_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire cmm_pkg::size_t  cfg_data,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire cmm_pkg::sts_t   sts,
	output cmm_pkg::cmd_t        cmd
);

	cmm_pkg::state_t state_q, state_nx;
	cmm_pkg::size_t  size_q;
	cmm_pkg::size_t  n_act;
	cmm_pkg::idx_t   nm1;
	cmm_pkg::cnt_t   total;
	cmm_pkg::cnt_t   cnt_q, cnt_inc;
	cmm_pkg::idx_t   i_q, j_q, t_q;
	logic            in_acc, load_done, el_fin, el_last;

	always_comb begin
		if (size_q == '0) begin
			n_act = cmm_pkg::size_t'(1);
		end else if (size_q > cmm_pkg::size_t'(cmm_pkg::MAX_SIZE)) begin
			n_act = cmm_pkg::size_t'(cmm_pkg::MAX_SIZE);
		end else begin
			n_act = size_q;
		end
	end

	assign nm1       = cmm_pkg::idx_t'(n_act - cmm_pkg::size_t'(1));
	assign total     = cmm_pkg::cnt_t'(cmm_pkg::cnt_t'(n_act) * cmm_pkg::cnt_t'(n_act));
	assign cnt_inc   = cnt_q + cmm_pkg::cnt_t'(1);
	assign in_stall  = (state_q != cmm_pkg::ST_LOAD);
	assign in_acc    = in_valid && !in_stall;
	assign load_done = in_acc && (cnt_inc >= total);
	assign el_fin    = (t_q == nm1);
	assign el_last   = (i_q == nm1) && (j_q == nm1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmm_pkg::ST_LOAD;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx    = state_q;
		cmd.wr_en   = in_acc;
		cmd.wr_addr = cnt_q[cmm_pkg::ADDR_W-1:0];
		cmd.rd_en   = 1'b0;
		cmd.a_addr  = cmm_pkg::addr_t'(cmm_pkg::cnt_t'(i_q) * cmm_pkg::cnt_t'(n_act)
			+ cmm_pkg::cnt_t'(t_q));
		cmd.b_addr  = cmm_pkg::addr_t'(cmm_pkg::cnt_t'(t_q) * cmm_pkg::cnt_t'(n_act)
			+ cmm_pkg::cnt_t'(j_q));
		cmd.first   = (t_q == '0);
		cmd.fin     = el_fin;
		cmd.row     = i_q;
		cmd.col     = j_q;
		cmd.last    = el_last;
		unique case (state_q)
			cmm_pkg::ST_LOAD: begin
				if (load_done) begin
					state_nx = cmm_pkg::ST_WAIT;
				end
			end
			cmm_pkg::ST_WAIT: begin
				if (sts.pipe_empty && !sts.out_full) begin
					state_nx = cmm_pkg::ST_ISSUE;
				end
			end
			cmm_pkg::ST_ISSUE: begin
				cmd.rd_en = 1'b1;
				if (el_fin) begin
					state_nx = el_last ? cmm_pkg::ST_LOAD : cmm_pkg::ST_WAIT;
				end
			end
			default: begin
				state_nx = cmm_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= cmm_pkg::size_t'(cmm_pkg::MAX_SIZE);
			cnt_q  <= '0;
			i_q    <= '0;
			j_q    <= '0;
			t_q    <= '0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_data;
			end
			if (load_done) begin
				cnt_q <= '0;
			end else if (in_acc) begin
				cnt_q <= cnt_inc;
			end
			if (state_q == cmm_pkg::ST_ISSUE) begin
				if (el_fin) begin
					t_q <= '0;
					if (j_q == nm1) begin
						j_q <= '0;
						i_q <= (i_q == nm1) ? '0 : i_q + cmm_pkg::idx_t'(1);
					end else begin
						j_q <= j_q + cmm_pkg::idx_t'(1);
					end
				end else begin
					t_q <= t_q + cmm_pkg::idx_t'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/cmm_dp.sv
`default_nettype none

module cmm_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmm_pkg::cmd_t     cmd,
	input  wire cmm_pkg::in_word_t in_data,
	output cmm_pkg::sts_t          sts,
	output cmm_pkg::out_word_t     out_data,
	output logic                   out_valid,
	input  wire logic              out_stall
);

	typedef struct packed {
		logic          first;
		logic          fin;
		cmm_pkg::idx_t row;
		cmm_pkg::idx_t col;
		logic          last;
	} tag_t;

	logic [cmm_pkg::WORD_W-1:0] mem_a [cmm_pkg::DEPTH];
	logic [cmm_pkg::WORD_W-1:0] mem_b [cmm_pkg::DEPTH];

	logic [cmm_pkg::WORD_W-1:0] a_s1, b_s1;
	tag_t              tag_s1, tag_s2, tag_s3;
	logic              valid_s1, valid_s2, valid_s3;
	cmm_pkg::prod_t    rr_s2, ii_s2, ri_s2, ir_s2;
	cmm_pkg::res_t     re_s3, im_s3;
	cmm_pkg::res_t     re_acc_q, im_acc_q, re_sum, im_sum;
	cmm_pkg::out_word_t out_q;
	logic              out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_a[cmd.wr_addr] <= {in_data.a_imag, in_data.a_real};
			mem_b[cmd.wr_addr] <= {in_data.b_imag, in_data.b_real};
		end
		if (cmd.rd_en) begin
			a_s1 <= mem_a[cmd.a_addr];
			b_s1 <= mem_b[cmd.b_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= '{first: cmd.first, fin: cmd.fin, row: cmd.row, col: cmd.col,
			last: cmd.last};
		tag_s2 <= tag_s1;
		tag_s3 <= tag_s2;
		rr_s2 <= $signed(a_s1[cmm_pkg::DATA_W-1:0]) * $signed(b_s1[cmm_pkg::DATA_W-1:0]);
		ii_s2 <= $signed(a_s1[cmm_pkg::WORD_W-1:cmm_pkg::DATA_W])
			* $signed(b_s1[cmm_pkg::WORD_W-1:cmm_pkg::DATA_W]);
		ri_s2 <= $signed(a_s1[cmm_pkg::DATA_W-1:0])
			* $signed(b_s1[cmm_pkg::WORD_W-1:cmm_pkg::DATA_W]);
		ir_s2 <= $signed(a_s1[cmm_pkg::WORD_W-1:cmm_pkg::DATA_W])
			* $signed(b_s1[cmm_pkg::DATA_W-1:0]);
		re_s3 <= cmm_pkg::res_t'(rr_s2) - cmm_pkg::res_t'(ii_s2);
		im_s3 <= cmm_pkg::res_t'(ri_s2) + cmm_pkg::res_t'(ir_s2);
		if (valid_s3) begin
			re_acc_q <= re_sum;
			im_acc_q <= im_sum;
		end
		if (valid_s3 && tag_s3.fin) begin
			out_q.row_index <= tag_s3.row;
			out_q.col_index <= tag_s3.col;
			out_q.r_real    <= re_sum;
			out_q.r_imag    <= im_sum;
			out_q.last      <= tag_s3.last;
		end
	end

	assign re_sum = tag_s3.first ? re_s3 : re_acc_q + re_s3;
	assign im_sum = tag_s3.first ? im_s3 : im_acc_q + im_s3;

	// hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s3 && tag_s3.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_data       = out_q;
	assign out_valid      = out_valid_q;
	assign sts.pipe_empty = !(valid_s1 || valid_s2 || valid_s3);
	assign sts.out_full   = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/complex_matrix_multiply_unit.sv
// Complex square matrix multiplier, R = A x B, n by n with n from cfg_data (1 to 8; 0 acts
// as 1, larger values as 8). Each input word carries one element of A and one of B in
// row-major order, Q8.8; words are taken one per cycle while loading. The word that
// completes n*n elements starts the product, and no input word is taken until every
// result element has been issued. Each result element reads its n term pairs from the
// two element memories, one pair per cycle, then passes a read, multiply, combine and
// accumulate pipeline; the next element starts only once that pipeline has drained and
// the pending result word has been taken, so out_stall holding results back slows it.
// Results come out in row-major order as Q20.16 with last marking the final element.
// Write the size register only while the block is idle; the block does not enforce it,
// and a size change in the middle of a load keeps the elements already loaded.
`default_nettype none

module complex_matrix_multiply_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire cmm_pkg::size_t     cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire cmm_pkg::in_word_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output cmm_pkg::out_word_t      out_data
);

	cmm_pkg::cmd_t cmd;
	cmm_pkg::sts_t sts;

	cmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cmm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.sts       (sts),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

`ifndef SYNTHESIS
	a_no_rd_wr: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_en && cmd.rd_en))
		else $error("memory read and write in the same cycle");

	a_first_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en && cmd.first |-> !out_valid && sts.pipe_empty)
		else $error("element started with result word still pending");

	a_pause_after_el: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en && cmd.fin |=> !cmd.rd_en && (in_stall == !$past(cmd.last)))
		else $error("controller did not pause after an element");
`endif

endmodule

`default_nettype wire
